// ===== rtl/lpe_pkg.sv =====
package lpe_pkg;

	// input word, first field in the most significant bits
	typedef struct packed {
		logic [1:0] action;
		logic [9:0] pixel_index;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} cmd_t;

	// result word
	typedef struct packed {
		logic line_level;
		logic busy_res;
		logic frame_done;
	} res_t;

	// action codes
	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_SHOW  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;
	localparam logic [1:0] ACT_TICK  = 2'd3;

	// register indexes
	localparam logic [2:0] REG_ENABLE    = 3'd0;
	localparam logic [2:0] REG_LED_COUNT = 3'd1;
	localparam logic [2:0] REG_ZERO_HIGH = 3'd2;
	localparam logic [2:0] REG_ZERO_LOW  = 3'd3;
	localparam logic [2:0] REG_ONE_HIGH  = 3'd4;
	localparam logic [2:0] REG_ONE_LOW   = 3'd5;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 11;
	localparam int COUNT_W = 11;
	localparam int TICKS_W = 6;
	localparam int PIXEL_W = 24;
	localparam int BITPOS_W = 5;
	localparam int INDEX_W = 10;

	localparam logic [TICKS_W-1:0] ZERO_HIGH_RST = 6'd14;
	localparam logic [TICKS_W-1:0] ZERO_LOW_RST  = 6'd34;
	localparam logic [TICKS_W-1:0] ONE_HIGH_RST  = 6'd34;
	localparam logic [TICKS_W-1:0] ONE_LOW_RST   = 6'd14;
	localparam logic [BITPOS_W-1:0] BIT_TOP = 5'd23;

	// a phase length of zero runs for one tick
	function automatic logic [TICKS_W-1:0] phase_ticks(input logic [TICKS_W-1:0] v);
		phase_ticks = (v == '0) ? TICKS_W'(1) : v;
	endfunction

endpackage

// ===== rtl/led_strip_pulse_encoder_unit.sv =====
// One-wire LED strip encoder. Pixels (green, red, blue, 24 bits) live in a
// MAX_LEDS-entry synchronous memory; a write word stores one pixel, a show word
// starts a frame over the first led_count pixels, a clear word sends an all-zero
// frame and zeroes each entry as it goes. Time only moves on tick words, one
// line slot each, and every word gives exactly one result word. The
// block takes one word per clock cycle while the output stage has room and
// no zeroing sweep runs; a word touches the memory at most once, either a
// pixel write or one read (or zero write) of the next pixel at a frame start
// or LED boundary, and fetched data is folded in the following cycle.
// Results go through a two-entry output stage, so a waiting result does not
// stop intake until the second entry fills. After reset the block zeroes the
// whole pixel memory before it takes any word; config writes are taken throughout.
module led_strip_pulse_encoder_unit
	import lpe_pkg::*;
#(
	parameter int MAX_LEDS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmd_valid,
	output logic                  cmd_ready,
	input  cmd_t                  cmd,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_t                  res,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// memory address width and led counter width
	localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam int CW_MIN = $clog2(MAX_LEDS + 1);
	localparam int CW = (CW_MIN > COUNT_W) ? CW_MIN : COUNT_W;
	localparam logic [CW-1:0] MAX_CNT = CW'(MAX_LEDS);
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_LEDS - 1);

	// configuration registers
	logic                enable_q;
	logic [COUNT_W-1:0]  led_count_q;
	logic [TICKS_W-1:0]  zero_high_q, zero_low_q, one_high_q, one_low_q;

	// pixel memory
	logic [PIXEL_W-1:0]  pix_mem [MAX_LEDS];
	logic                mem_we, mem_re;
	logic [AW-1:0]       mem_wa, mem_ra;
	logic [PIXEL_W-1:0]  mem_wd, mem_rd_q;

	// power-up zeroing sweep
	logic                init_busy_q;
	logic [AW-1:0]       init_addr_q;

	// frame state
	logic                sending_q, sending_d;
	logic                clearing_q, clearing_d;
	logic [CW-1:0]       pos_q, pos_d;
	logic [BITPOS_W-1:0] bit_q, bit_d;
	logic                high_q, high_d;
	logic [TICKS_W-1:0]  phase_q, phase_d;
	logic [PIXEL_W-1:0]  shift_q, shift_d;
	// a pixel load is in flight: its data is in mem_rd_q this cycle
	logic                pend_q, pend_d;
	logic [TICKS_W-1:0]  zh_snap_q, zh_snap_d, oh_snap_q, oh_snap_d;

	// working values
	logic                cmd_fire, res_fire;
	logic [CW-1:0]       eff_cnt, idx_ext, pos_inc;
	logic [PIXEL_W-1:0]  eff_shift;
	logic [TICKS_W-1:0]  eff_phase, phase_dec;
	logic [BITPOS_W-1:0] bit_dn;
	logic                load_en, load_clr;
	logic [CW-1:0]       load_pos;
	res_t                res_new;

	// output stage: main entry plus one skid entry
	logic                out_v_q, skid_v_q;
	res_t                out_q, skid_q;

	assign cmd_fire = cmd_valid && cmd_ready;
	assign res_fire = out_v_q && res_ready;
	assign cmd_ready = !skid_v_q && !init_busy_q;
	assign cfg_ready = 1'b1;
	assign res_valid = out_v_q;
	assign res = out_q;

	// led_count saturated to the memory depth
	assign eff_cnt = (CW'(led_count_q) > MAX_CNT) ? MAX_CNT : CW'(led_count_q);
	assign idx_ext = CW'(cmd.pixel_index);

	// fold in a pixel fetched last cycle
	assign eff_shift = pend_q ? (clearing_q ? '0 : mem_rd_q) : shift_q;
	assign eff_phase = pend_q ? (eff_shift[PIXEL_W-1] ? oh_snap_q : zh_snap_q) : phase_q;
	assign phase_dec = (eff_phase != '0) ? eff_phase - TICKS_W'(1) : '0;
	assign bit_dn = bit_q - BITPOS_W'(1);
	assign pos_inc = pos_q + CW'(1);

	always_comb begin
		sending_d = sending_q;
		clearing_d = clearing_q;
		pos_d = pos_q;
		bit_d = bit_q;
		high_d = high_q;
		phase_d = eff_phase;
		shift_d = eff_shift;
		pend_d = 1'b0;
		zh_snap_d = zh_snap_q;
		oh_snap_d = oh_snap_q;
		load_en = 1'b0;
		load_clr = 1'b0;
		load_pos = '0;
		res_new = '0;
		mem_we = 1'b0;
		mem_wa = init_addr_q;
		mem_wd = '0;
		mem_re = 1'b0;
		mem_ra = '0;

		if (init_busy_q) begin
			mem_we = 1'b1;
		end

		if (cmd_fire) begin
			unique case (cmd.action)
				ACT_WRITE: begin
					if (enable_q && !sending_q && idx_ext < eff_cnt) begin
						mem_we = 1'b1;
						mem_wa = idx_ext[AW-1:0];
						mem_wd = {cmd.green, cmd.red, cmd.blue};
					end
					res_new.busy_res = sending_q;
				end
				ACT_SHOW, ACT_CLEAR: begin
					if (enable_q && !sending_q && eff_cnt != '0) begin
						sending_d = 1'b1;
						clearing_d = (cmd.action == ACT_CLEAR);
						load_en = 1'b1;
						load_clr = (cmd.action == ACT_CLEAR);
						load_pos = '0;
					end
					res_new.busy_res = sending_d;
				end
				ACT_TICK: begin
					res_new.busy_res = sending_q;
					if (sending_q) begin
						res_new.line_level = high_q;
						if (phase_dec != '0) begin
							phase_d = phase_dec;
						end else if (high_q) begin
							high_d = 1'b0;
							phase_d = eff_shift[bit_q] ? phase_ticks(one_low_q)
								: phase_ticks(zero_low_q);
						end else if (bit_q != '0) begin
							bit_d = bit_dn;
							high_d = 1'b1;
							phase_d = eff_shift[bit_dn] ? phase_ticks(one_high_q)
								: phase_ticks(zero_high_q);
						end else if (pos_inc >= eff_cnt) begin
							// last bit of the last led
							sending_d = 1'b0;
							clearing_d = 1'b0;
							pos_d = '0;
							bit_d = BIT_TOP;
							high_d = 1'b1;
							phase_d = '0;
							res_new.frame_done = 1'b1;
						end else begin
							load_en = 1'b1;
							load_clr = clearing_q;
							load_pos = pos_inc;
						end
					end
				end
			endcase
		end

		// pixel load: fetch, or zero the entry on a clear frame
		if (load_en) begin
			pos_d = load_pos;
			bit_d = BIT_TOP;
			high_d = 1'b1;
			pend_d = 1'b1;
			zh_snap_d = phase_ticks(zero_high_q);
			oh_snap_d = phase_ticks(one_high_q);
			if (load_clr) begin
				mem_we = 1'b1;
				mem_wa = load_pos[AW-1:0];
				mem_wd = '0;
			end else begin
				mem_re = 1'b1;
				mem_ra = load_pos[AW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pix_mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			mem_rd_q <= pix_mem[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_busy_q <= 1'b1;
			init_addr_q <= '0;
		end else if (init_busy_q) begin
			init_addr_q <= init_addr_q + AW'(1);
			if (init_addr_q == LAST_ADDR) begin
				init_busy_q <= 1'b0;
			end
		end
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			led_count_q <= '0;
			zero_high_q <= ZERO_HIGH_RST;
			zero_low_q <= ZERO_LOW_RST;
			one_high_q <= ONE_HIGH_RST;
			one_low_q <= ONE_LOW_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ENABLE:    enable_q <= cfg_data[0];
				REG_LED_COUNT: led_count_q <= cfg_data[COUNT_W-1:0];
				REG_ZERO_HIGH: zero_high_q <= cfg_data[TICKS_W-1:0];
				REG_ZERO_LOW:  zero_low_q <= cfg_data[TICKS_W-1:0];
				REG_ONE_HIGH:  one_high_q <= cfg_data[TICKS_W-1:0];
				REG_ONE_LOW:   one_low_q <= cfg_data[TICKS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sending_q <= 1'b0;
			clearing_q <= 1'b0;
			pos_q <= '0;
			bit_q <= BIT_TOP;
			high_q <= 1'b1;
			phase_q <= '0;
			shift_q <= '0;
			pend_q <= 1'b0;
			zh_snap_q <= '0;
			oh_snap_q <= '0;
		end else begin
			sending_q <= sending_d;
			clearing_q <= clearing_d;
			pos_q <= pos_d;
			bit_q <= bit_d;
			high_q <= high_d;
			phase_q <= phase_d;
			shift_q <= shift_d;
			pend_q <= pend_d;
			zh_snap_q <= zh_snap_d;
			oh_snap_q <= oh_snap_d;
		end
	end

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (cmd_fire) begin
			if (!out_v_q || res_fire) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end else if (res_fire) begin
			out_v_q <= skid_v_q;
			skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			if (!out_v_q || res_fire) begin
				out_q <= res_new;
			end else begin
				skid_q <= res_new;
			end
		end else if (res_fire) begin
			out_q <= skid_q;
		end
	end

	// checks
	a_pend_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> sending_q)
		else $error("pixel load pending outside a frame");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		bit_q <= BIT_TOP)
		else $error("bit position out of range");

	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held while main entry empty");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_q.frame_done) |-> out_q.busy_res)
		else $error("frame done without busy");

	a_mem_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_re && mem_we))
		else $error("memory read and write in one cycle");

	a_idle_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_fire && res_new.frame_done) |=> !sending_q)
		else $error("frame still running after done");

endmodule
